/* sv/ceg_pkg.sv */
// Shared types and constants for the coincidence event gate.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ceg_pkg;

  // Default number of coincidence slots
  localparam int CEG_SLOTS = 16;
  // Depth of the queue between front and back
  localparam int CEG_QDEPTH = 2;

  localparam int CEG_CFG_IDX_W = 3;
  localparam int CEG_CFG_DATA_W = 32;

  // Raw input kinds
  localparam logic [1:0] KIND_TRIG = 2'd1;
  localparam logic [1:0] KIND_BLOCK = 2'd2;

  // Result outcomes
  localparam logic OUT_PASS = 1'b0;
  localparam logic OUT_FILT = 1'b1;

  typedef enum logic [CEG_CFG_IDX_W-1:0] {
    CFG_TARGET = 3'd0,
    CFG_WINDOW = 3'd1,
    CFG_BLOCKOUT = 3'd2,
    CFG_SYNC = 3'd3,
    CFG_NEEDED = 3'd4
  } ceg_cfg_idx_e;

  // Classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_TRIG = 2'd1,
    OP_BLOCK = 2'd2
  } ceg_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT0,
    ST_EMIT1
  } ceg_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [15:0] event_code;
    logic [63:0] stamp;
    logic [31:0] now;
  } ceg_in_t;

  typedef struct packed {
    logic outcome;
    logic [63:0] out_stamp;
    logic [4:0] match_count;
    logic [31:0] blocked_total;
    logic last;
  } ceg_out_t;

  typedef struct packed {
    logic [15:0] target_code;
    logic [31:0] window_ticks;
    logic [31:0] blockout_ticks;
    logic [31:0] sync_ticks;
    logic [4:0] needed_slots;
  } ceg_cfg_t;

  typedef struct packed {
    ceg_op_e op;
    logic [3:0] slot;
    logic [63:0] stamp;
    logic [31:0] now;
  } ceg_item_t;

endpackage

`default_nettype wire

/* sv/coincidence_event_gate.sv */
// Coincidence event gate: top level with configuration registers.
// Instantiates ceg_front, ceg_queue and ceg_back; needs ceg_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one beat per tick,
//   trigger-port event or blocking-port event; every beat carries the time.
//   Output channel (out_valid_o/out_ready_i/out_data_o) delivers zero, one
//   or two results per input beat; last marks the final one of a beat.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i in
//   the same cycle; write only while the block is idle.
// Sequencing:
//   A trigger event with no detection pending runs a scan in the back end
//   that reads one slot time a cycle from the slot-time memory; ticks and
//   blocking events skip the scan. A two-entry queue lets the front accept
//   beats while the back end is busy with one operation at a time.
// Reset: all slots unseen, gate open, nothing pending, blocked count zero,
//   registers at their defaults. No clearing pass is needed.
// Stall: a waiting result is held in the output register; the back end
//   waits on it and the queue then fills until in_ready_o drops.
`default_nettype none

module coincidence_event_gate import ceg_pkg::*; #(
  parameter int SLOTS = CEG_SLOTS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire ceg_in_t                   in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output ceg_out_t                       out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [CEG_CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CEG_CFG_DATA_W-1:0] cfg_wdata_i
);

  ceg_cfg_t cfg_q;
  logic push, q_full, q_vld, q_pop;
  ceg_item_t push_item, q_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_code <= '0;
      cfg_q.window_ticks <= 32'd1000;
      cfg_q.blockout_ticks <= '0;
      cfg_q.sync_ticks <= '0;
      cfg_q.needed_slots <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET:   cfg_q.target_code <= cfg_wdata_i[15:0];
        CFG_WINDOW:   cfg_q.window_ticks <= cfg_wdata_i;
        CFG_BLOCKOUT: cfg_q.blockout_ticks <= cfg_wdata_i;
        CFG_SYNC:     cfg_q.sync_ticks <= cfg_wdata_i;
        CFG_NEEDED:   cfg_q.needed_slots <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  ceg_front #(.SLOTS(SLOTS)) u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .target_code_i (cfg_q.target_code),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (push_item)
  );

  ceg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (q_full),
    .vld_o  (q_vld),
    .pop_i  (q_pop),
    .item_o (q_item)
  );

  ceg_back #(.SLOTS(SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_vld_i     (q_vld),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sv/ceg_front.sv */
// Front end: accepts input beats and classifies them into operations.
// Depends on ceg_pkg.
`default_nettype none

module ceg_front import ceg_pkg::*; #(
  parameter int SLOTS = CEG_SLOTS
) (
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ceg_in_t   in_data_i,
  input  wire logic [15:0] target_code_i,
  input  wire logic      q_full_i,
  output logic           push_o,
  output ceg_item_t      item_o
);

  logic match;

  // Accept while the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o = in_valid_i && !q_full_i;

  // Target code on an existing slot
  assign match = (in_data_i.event_code == target_code_i) &&
                 (32'(in_data_i.slot) < 32'(SLOTS));

  // Classify; anything that is not a matching event only advances time
  always_comb begin
    item_o.slot = in_data_i.slot;
    item_o.stamp = in_data_i.stamp;
    item_o.now = in_data_i.now;
    if (match && in_data_i.kind == KIND_TRIG) begin
      item_o.op = OP_TRIG;
    end else if (match && in_data_i.kind == KIND_BLOCK) begin
      item_o.op = OP_BLOCK;
    end else begin
      item_o.op = OP_TICK;
    end
  end

endmodule

`default_nettype wire

/* sv/ceg_queue.sv */
// Short FIFO of classified operations between front and back.
// Depends on ceg_pkg.
`default_nettype none

module ceg_queue import ceg_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ceg_item_t item_i,
  output logic           full_o,
  output logic           vld_o,
  input  wire logic      pop_i,
  output ceg_item_t      item_o
);

  localparam int PTR_W = (CEG_QDEPTH > 1) ? $clog2(CEG_QDEPTH) : 1;
  localparam int CNT_W = $clog2(CEG_QDEPTH + 1);

  ceg_item_t mem_q [CEG_QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o = (cnt_q == CNT_W'(CEG_QDEPTH));
  assign vld_o = (cnt_q != '0);
  assign item_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == CEG_QDEPTH - 1) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == CEG_QDEPTH - 1) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

/* sv/ceg_back.sv */
// Back end: sequencer that applies one operation at a time, scans the
// slot times for coincidences and drives the result register. Needs ceg_pkg.
`default_nettype none

module ceg_back import ceg_pkg::*; #(
  parameter int SLOTS = CEG_SLOTS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ceg_cfg_t  cfg_i,
  input  wire logic      q_vld_i,
  input  wire ceg_item_t q_item_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ceg_out_t       out_data_o
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W = $clog2(SLOTS + 1);
  localparam int CNT_W = $clog2(SLOTS + 1);

  ceg_state_e state_q, state_d;
  ceg_item_t cur_q;

  logic pend_q;
  logic [31:0] pend_start_q;
  logic [63:0] pend_stamp_q;
  logic [4:0] pend_count_q;
  logic gate_armed_q;
  logic [31:0] gate_time_q;
  logic [31:0] blocked_q;

  logic exp_vld_q, res2_vld_q;
  ceg_out_t exp_res_q, res2_q;

  logic [SLOTS-1:0] seen_q;
  logic [31:0] slot_time_mem [SLOTS];
  logic [IDX_W-1:0] scan_idx_q;
  logic rd_vld_q, rd_seen_q;
  logic [31:0] rd_time_q;
  logic [CNT_W-1:0] cnt_q;

  logic out_vld_q;
  ceg_out_t out_q;

  logic [SLOT_W-1:0] slot_idx;
  logic exp_hit, pend_eff, is_trig, is_blk, in_window, gate_hit, det, scan_done;
  logic out_free, ld_exp, ld_res2, mem_we, scan_rd;
  logic [31:0] blk_inc;
  logic [4:0] cnt5;

  assign slot_idx = SLOT_W'(cur_q.slot);
  assign is_trig = (cur_q.op == OP_TRIG);
  assign is_blk = (cur_q.op == OP_BLOCK);
  assign exp_hit = pend_q && ((cur_q.now - pend_start_q) >= cfg_i.sync_ticks);
  assign pend_eff = pend_q && !exp_hit;
  assign in_window = rd_seen_q && ((cur_q.now - rd_time_q) < cfg_i.window_ticks);
  assign gate_hit = gate_armed_q && ((cur_q.now - gate_time_q) <= cfg_i.blockout_ticks);
  assign det = (32'(cnt_q) >= 32'(cfg_i.needed_slots));
  assign scan_done = (scan_idx_q == IDX_W'(SLOTS));
  assign blk_inc = (blocked_q == '1) ? blocked_q : blocked_q + 32'd1;
  assign cnt5 = 5'(cnt_q);
  assign out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_data_o = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (q_vld_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = (!pend_eff && is_trig) ? ST_SCAN : ST_EMIT0;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT0;
      ST_EMIT0:  if (!exp_vld_q || out_free) state_d = ST_EMIT1;
      ST_EMIT1:  if (!res2_vld_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    q_pop_o = (state_q == ST_IDLE) && q_vld_i;
    mem_we = (state_q == ST_CHECK) && !pend_eff && is_trig;
    scan_rd = (state_q == ST_SCAN) && !scan_done;
    ld_exp = (state_q == ST_EMIT0) && exp_vld_q && out_free;
    ld_res2 = (state_q == ST_EMIT1) && res2_vld_q && out_free;
  end

  // Sequencer state, gate and pending detection
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q <= 1'b0;
      gate_armed_q <= 1'b0;
      blocked_q <= '0;
      exp_vld_q <= 1'b0;
      res2_vld_q <= 1'b0;
      seen_q <= '0;
      scan_idx_q <= '0;
      rd_vld_q <= 1'b0;
      cnt_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;

      unique case (state_q)
        ST_CHECK: begin
          // Expire a pending detection first, then apply the operation
          exp_vld_q <= exp_hit;
          res2_vld_q <= pend_eff && is_blk;
          if (exp_hit) pend_q <= 1'b0;
          if (pend_eff) begin
            if (is_blk) begin
              pend_q <= 1'b0;
              blocked_q <= blk_inc;
              gate_armed_q <= 1'b1;
            end
          end else if (is_trig) begin
            seen_q[slot_idx] <= 1'b1;
            cnt_q <= '0;
            scan_idx_q <= '0;
            rd_vld_q <= 1'b0;
          end else if (is_blk) begin
            gate_armed_q <= 1'b1;
          end
        end
        ST_SCAN: begin
          // Read one slot a cycle; tally the previous read
          rd_vld_q <= scan_rd;
          if (scan_rd) begin
            rd_seen_q <= seen_q[scan_idx_q[SLOT_W-1:0]];
            scan_idx_q <= scan_idx_q + IDX_W'(1);
          end
          if (rd_vld_q && in_window) cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_DECIDE: begin
          if (det) begin
            if (gate_hit) begin
              blocked_q <= blk_inc;
              res2_vld_q <= 1'b1;
            end else if (cfg_i.sync_ticks == '0) begin
              res2_vld_q <= 1'b1;
            end else begin
              pend_q <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      // Output register
      if (ld_exp || ld_res2) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_item_i;
    if (state_q == ST_CHECK) begin
      exp_res_q <= '{outcome: OUT_PASS, out_stamp: pend_stamp_q,
                     match_count: pend_count_q, blocked_total: blocked_q,
                     last: 1'b0};
      if (pend_eff && is_blk) begin
        gate_time_q <= cur_q.now;
        res2_q <= '{outcome: OUT_FILT, out_stamp: pend_stamp_q,
                    match_count: pend_count_q, blocked_total: blk_inc,
                    last: 1'b1};
      end else if (!pend_eff && is_blk) begin
        gate_time_q <= cur_q.now;
      end
    end
    if (state_q == ST_DECIDE && det) begin
      if (gate_hit) begin
        res2_q <= '{outcome: OUT_FILT, out_stamp: cur_q.stamp,
                    match_count: cnt5, blocked_total: blk_inc, last: 1'b1};
      end else begin
        res2_q <= '{outcome: OUT_PASS, out_stamp: cur_q.stamp,
                    match_count: cnt5, blocked_total: blocked_q, last: 1'b1};
      end
      pend_start_q <= cur_q.now;
      pend_stamp_q <= cur_q.stamp;
      pend_count_q <= cnt5;
    end
    if (ld_exp) begin
      // Expired detection is the final beat unless a second result follows
      out_q <= '{outcome: exp_res_q.outcome, out_stamp: exp_res_q.out_stamp,
                 match_count: exp_res_q.match_count,
                 blocked_total: exp_res_q.blocked_total, last: !res2_vld_q};
    end else if (ld_res2) begin
      out_q <= res2_q;
    end
  end

  // Slot arrival times
  always_ff @(posedge clk_i) begin
    if (mem_we) slot_time_mem[slot_idx] <= cur_q.now;
    if (scan_rd) rd_time_q <= slot_time_mem[scan_idx_q[SLOT_W-1:0]];
  end

endmodule

`default_nettype wire

/* sv/ceg_checker.sv */
// Port-level checker for the coincidence event gate, bound to the top level.
// Needs ceg_pkg.
`default_nettype none

module ceg_checker import ceg_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire ceg_out_t out_data_o
);

  logic out_acc;
  logic [31:0] prev_blk_q;
  logic [31:0] prev_inc;

  assign out_acc = out_valid_o && out_ready_i;
  assign prev_inc = (prev_blk_q == '1) ? prev_blk_q : prev_blk_q + 32'd1;

  // Track the blocked count of the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_blk_q <= '0;
    end else if (out_acc) begin
      prev_blk_q <= out_data_o.blocked_total;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_filt_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.outcome == OUT_FILT |-> out_data_o.blocked_total == prev_inc)
    else $error("filtered result did not bump blocked count");

  a_pass_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_data_o.outcome == OUT_PASS |-> out_data_o.blocked_total == prev_blk_q)
    else $error("passed result changed blocked count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.match_count <= 5'd16)
    else $error("match count above slot range");

endmodule

bind coincidence_event_gate ceg_checker u_ceg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
